/* rtl/id_tagged_overwrite_ring_buffer_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the id tagged overwrite ring buffer
// Same-cycle and next-cycle implication checks, reset-gated.
// ----------------------------------------------------------------------------
`ifndef ID_TAGGED_OVERWRITE_RING_BUFFER_UNIT_MACROS_SVH
`define ID_TAGGED_OVERWRITE_RING_BUFFER_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ITORB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ITORB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/itorb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itorb_pkg
// Sizes, codes and control/status bundles of the id tagged ring buffer.
// ----------------------------------------------------------------------------
package itorb_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ID_W       = 48;

    localparam int ACT_W  = 3;
    localparam int STAT_W = 2;
    localparam int REQ_W  = 7;
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int SUM_W  = SLOT_W + 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH   = 3'd0,
        ACT_RANGE  = 3'd1,
        ACT_SINGLE = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_STATUS = 3'd4
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NONE      = 2'd1,
        STAT_EXHAUSTED = 2'd2
    } t_status;

    typedef struct packed {
        logic latch;
        logic check;
        logic plan;
        logic load_resp;
        logic load_entry;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic out_free;
        logic last_entry;
    } t_sts;

endpackage

/* rtl/itorb_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itorb_req_if
// Request channel: valid/ready plus one command item.
// ----------------------------------------------------------------------------
interface itorb_req_if import itorb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [ACT_W-1:0]      action;
    logic [DATA_WIDTH-1:0] packet_word;
    logic [ID_W-1:0]       query_id;
    logic [REQ_W-1:0]      request_count;

    modport source (output valid, action, packet_word, query_id, request_count,
                    input ready);
    modport sink   (input valid, action, packet_word, query_id, request_count,
                    output ready);
endinterface

/* rtl/itorb_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itorb_rsp_if
// Response channel: valid/ready plus one result item.
// ----------------------------------------------------------------------------
interface itorb_rsp_if import itorb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [STAT_W-1:0]     status;
    logic [ID_W-1:0]       entry_id;
    logic [DATA_WIDTH-1:0] entry_data;
    logic [REQ_W-1:0]      stored_count;
    logic [ID_W-1:0]       oldest_seq;
    logic [ID_W-1:0]       newest_seq;
    logic                  last;

    modport source (output valid, status, entry_id, entry_data, stored_count,
                    oldest_seq, newest_seq, last, input ready);
    modport sink   (input valid, status, entry_id, entry_data, stored_count,
                    oldest_seq, newest_seq, last, output ready);
endinterface

/* rtl/itorb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itorb_ctrl
// Sequencer: accept, check, then emit one response, or plan and emit a burst of entries.
// ----------------------------------------------------------------------------
module itorb_ctrl import itorb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_PLAN  = 5'b00100,
        S_RESP  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.latch = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state = i_sts.hit ? S_PLAN : S_RESP;
            end
            S_PLAN: begin
                o_cmd.plan = 1'b1;
                n_state = S_EMIT;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.load_resp = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_entry = 1'b1;
                    if (i_sts.last_entry) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/itorb_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itorb_dp
// Ring store, id counter, range/lookup arithmetic and the result register.
// ----------------------------------------------------------------------------
`include "id_tagged_overwrite_ring_buffer_unit_macros.svh"

module itorb_dp import itorb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [ACT_W-1:0]      i_action,
    input  logic [DATA_WIDTH-1:0] i_packet_word,
    input  logic [ID_W-1:0]       i_query_id,
    input  logic [REQ_W-1:0]      i_request_count,
    itorb_rsp_if.source           o_rsp
);

    function automatic logic [SLOT_W-1:0] wrap_add(input logic [SLOT_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(CAPACITY)) begin
            s = s - SUM_W'(CAPACITY);
        end
        return s[SLOT_W-1:0];
    endfunction

    // ring store
    logic [DATA_WIDTH-1:0] mem_data [CAPACITY];
    logic [ID_W-1:0]       mem_ids  [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [ID_W-1:0]       r_rd_id;

    // control state
    logic [SLOT_W-1:0] r_head;
    logic [CNT_W-1:0]  r_held;
    logic [ID_W-1:0]   r_next_seq;
    logic [CNT_W-1:0]  r_remain;
    logic              r_o_valid;

    // latched request
    logic [ACT_W-1:0]      r_action;
    logic [DATA_WIDTH-1:0] r_packet_word;
    logic [ID_W-1:0]       r_query_id;
    logic [REQ_W-1:0]      r_request_count;

    // plan and response
    t_status               r_resp_status;
    logic [ID_W-1:0]       r_resp_id;
    logic [DATA_WIDTH-1:0] r_resp_data;
    logic [CNT_W-1:0]      r_off;
    logic [CNT_W-1:0]      r_cap;
    logic [SLOT_W-1:0]     r_ptr;

    // result register
    t_status               r_o_status;
    logic [ID_W-1:0]       r_o_id;
    logic [DATA_WIDTH-1:0] r_o_data;
    logic [REQ_W-1:0]      r_o_count;
    logic [ID_W-1:0]       r_o_oldest;
    logic [ID_W-1:0]       r_o_newest;
    logic                  r_o_last;

    logic [ID_W-1:0]       oldest;
    logic [ID_W-1:0]       newest;
    logic [ID_W-1:0]       diff;
    logic                  exhausted;
    logic                  full;
    logic                  clamp;
    logic                  range_hit;
    logic                  single_hit;
    logic [CNT_W-1:0]      req_sat;
    logic [CNT_W-1:0]      avail;
    logic [CNT_W-1:0]      n_count;
    logic [SLOT_W-1:0]     start_slot;
    logic                  push_ok;
    logic                  do_clear;
    t_status               n_resp_status;
    logic [ID_W-1:0]       n_resp_id;
    logic [DATA_WIDTH-1:0] n_resp_data;
    logic                  wr_en;
    logic                  rd_en;
    logic [SLOT_W-1:0]     rd_addr;
    logic                  out_free;

    assign oldest    = (r_held != '0) ? r_next_seq - ID_W'(r_held) : '0;
    assign newest    = (r_held != '0) ? r_next_seq - ID_W'(1) : '0;
    assign diff      = r_query_id - oldest;
    assign exhausted = &r_next_seq;
    assign full      = (r_held == CNT_W'(CAPACITY));
    assign req_sat   = (r_request_count > REQ_W'(CAPACITY)) ? CNT_W'(CAPACITY)
                                                            : CNT_W'(r_request_count);

    assign clamp      = (r_query_id == '0) || (r_query_id < oldest);
    assign range_hit  = (r_held != '0) && (req_sat != '0) &&
                        (clamp || (r_query_id <= newest));
    assign single_hit = (r_held != '0) && (r_query_id >= oldest) &&
                        (r_query_id <= newest);

    always_comb begin
        n_resp_status = STAT_OK;
        n_resp_id     = '0;
        n_resp_data   = '0;
        push_ok       = 1'b0;
        do_clear      = 1'b0;
        unique case (r_action)
            ACT_PUSH: begin
                if (exhausted) begin
                    n_resp_status = STAT_EXHAUSTED;
                end else begin
                    push_ok     = 1'b1;
                    n_resp_id   = r_next_seq;
                    n_resp_data = r_packet_word;
                end
            end
            ACT_RANGE:  n_resp_status = STAT_NONE;
            ACT_SINGLE: n_resp_status = STAT_NONE;
            ACT_CLEAR:  do_clear = 1'b1;
            ACT_STATUS: n_resp_status = STAT_OK;
            default:    n_resp_status = STAT_NONE;
        endcase
    end

    assign avail      = r_held - r_off;
    assign n_count    = (r_cap < avail) ? r_cap : avail;
    assign start_slot = wrap_add(r_head, r_off);

    assign out_free = !r_o_valid || o_rsp.ready;
    assign wr_en    = i_cmd.check && push_ok;
    assign rd_en    = i_cmd.plan || (i_cmd.load_entry && (r_remain > CNT_W'(1)));
    assign rd_addr  = i_cmd.plan ? start_slot : r_ptr;

    assign o_sts.hit = ((r_action == ACT_RANGE) && range_hit) ||
                       ((r_action == ACT_SINGLE) && single_hit);
    assign o_sts.out_free   = out_free;
    assign o_sts.last_entry = (r_remain == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_data[wrap_add(r_head, r_held)] <= r_packet_word;
            mem_ids[wrap_add(r_head, r_held)]  <= r_next_seq;
        end
        if (rd_en) begin
            r_rd_data <= mem_data[rd_addr];
            r_rd_id   <= mem_ids[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_held     <= '0;
            r_next_seq <= ID_W'(1);
            r_remain   <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_next_seq <= r_next_seq + ID_W'(1);
                if (full) begin
                    r_head <= wrap_add(r_head, CNT_W'(1));
                end else begin
                    r_held <= r_held + CNT_W'(1);
                end
            end
            if (i_cmd.check && do_clear) begin
                r_head <= '0;
                r_held <= '0;
            end
            if (i_cmd.plan) begin
                r_remain <= n_count;
            end else if (i_cmd.load_entry) begin
                r_remain <= r_remain - CNT_W'(1);
            end
            if (i_cmd.load_resp || i_cmd.load_entry) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action        <= i_action;
            r_packet_word   <= i_packet_word;
            r_query_id      <= i_query_id;
            r_request_count <= i_request_count;
        end
        if (i_cmd.check) begin
            r_resp_status <= n_resp_status;
            r_resp_id     <= n_resp_id;
            r_resp_data   <= n_resp_data;
            if (r_action == ACT_SINGLE) begin
                r_off <= diff[CNT_W-1:0];
                r_cap <= CNT_W'(1);
            end else begin
                r_off <= clamp ? '0 : diff[CNT_W-1:0];
                r_cap <= req_sat;
            end
        end
        if (i_cmd.plan) begin
            r_ptr <= wrap_add(r_head, r_off + CNT_W'(1));
        end else if (rd_en) begin
            r_ptr <= wrap_add(r_ptr, CNT_W'(1));
        end
        if (i_cmd.load_resp || i_cmd.load_entry) begin
            r_o_count  <= REQ_W'(r_held);
            r_o_oldest <= oldest;
            r_o_newest <= newest;
        end
        if (i_cmd.load_resp) begin
            r_o_status <= r_resp_status;
            r_o_id     <= r_resp_id;
            r_o_data   <= r_resp_data;
            r_o_last   <= 1'b1;
        end else if (i_cmd.load_entry) begin
            r_o_status <= STAT_OK;
            r_o_id     <= r_rd_id;
            r_o_data   <= r_rd_data;
            r_o_last   <= (r_remain == CNT_W'(1));
        end
    end

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.status       = r_o_status;
    assign o_rsp.entry_id     = r_o_id;
    assign o_rsp.entry_data   = r_o_data;
    assign o_rsp.stored_count = r_o_count;
    assign o_rsp.oldest_seq   = r_o_oldest;
    assign o_rsp.newest_seq   = r_o_newest;
    assign o_rsp.last         = r_o_last;

    `ITORB_ASSERT_SAME(a_held_bound, i_clk, i_rst_n, 1'b1,
        r_held <= CNT_W'(CAPACITY), "held count above capacity")
    `ITORB_ASSERT_SAME(a_entry_pending, i_clk, i_rst_n, i_cmd.load_entry,
        r_remain != '0, "entry load with nothing pending")
    `ITORB_ASSERT_NEXT(a_refused_push, i_clk, i_rst_n,
        i_cmd.check && (r_action == ACT_PUSH) && exhausted,
        $stable(r_next_seq) && $stable(r_held) && $stable(r_head),
        "refused push changed state")
    `ITORB_ASSERT_NEXT(a_push_seq, i_clk, i_rst_n, wr_en,
        r_next_seq == $past(r_next_seq) + ID_W'(1), "push did not advance id counter")

endmodule

/* rtl/id_tagged_overwrite_ring_buffer_unit.sv */
`timescale 1ns / 1ps
// A single-result command is latched, checked, then loaded into the result register.
// A range read is latched, checked and planned, then emits one entry per cycle
// while the output is free. No new command is taken before the current one is done,
// as set by the check/plan sequencer and the single registered read port of the store.
// Reset (synchronous, active low): store empty, head 0, id counter 1, no result pending;
// stored words are not cleared.
// ----------------------------------------------------------------------------
// id_tagged_overwrite_ring_buffer_unit
// Overwriting ring store with sequence ids, range and single-id reads, clear and status.
// ----------------------------------------------------------------------------
module id_tagged_overwrite_ring_buffer_unit import itorb_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    itorb_req_if.sink    i_req,
    itorb_rsp_if.source  o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    itorb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    itorb_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_action        (i_req.action),
        .i_packet_word   (i_req.packet_word),
        .i_query_id      (i_req.query_id),
        .i_request_count (i_req.request_count),
        .o_rsp           (o_rsp)
    );

    assign i_req.ready = w_in_ready;

endmodule
